### hdl/crcfrd_pkg.sv
// Package: shared types, constants and the byte-wide CRC-32 step of the record decoder.
package crcfrd_pkg;

  // Record layout and framing
  localparam logic [4:0]  REC_LEN       = 5'd28;
  localparam logic [4:0]  CNT_SAT       = 5'd29;
  localparam logic [4:0]  POS_MAGIC_END = 5'd3;
  localparam logic [4:0]  POS_VER_LO    = 5'd4;
  localparam logic [4:0]  POS_VER_HI    = 5'd5;
  localparam logic [4:0]  POS_SIZE_LO   = 5'd6;
  localparam logic [4:0]  POS_SIZE_HI   = 5'd7;
  localparam logic [4:0]  POS_CHK_LO    = 5'd8;
  localparam logic [4:0]  POS_CHK_HI    = 5'd11;
  localparam logic [4:0]  POS_TIME_LO   = 5'd12;
  localparam logic [4:0]  POS_TIME_HI   = 5'd19;
  localparam logic [4:0]  POS_REST_LO   = 5'd20;
  localparam logic [4:0]  POS_REST_HI   = 5'd27;

  // Header contents
  localparam logic [31:0] REC_MAGIC     = 32'h4E50_5743;
  localparam logic [7:0]  REC_VERSION   = 8'd1;
  localparam logic [7:0]  REC_SIZE      = 8'd16;
  localparam logic [7:0]  BYTE_ZERO     = 8'd0;

  // CRC-32, reflected
  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;

  // Payload limits
  localparam logic [7:0]  CODE_MAX      = 8'd99;
  localparam logic [15:0] WIND_MAX      = 16'd3000;
  localparam logic [7:0]  DAY_MAX       = 8'd1;

  // Status codes
  localparam logic        STATUS_OK     = 1'b0;
  localparam logic        STATUS_BAD    = 1'b1;

  typedef struct packed {
    logic [7:0] blob_byte;
    logic       blob_last;
  } in_item_t;

  typedef struct packed {
    logic               status;
    logic [63:0]        saved_time;
    logic signed [15:0] temperature;
    logic signed [15:0] apparent_temperature;
    logic [11:0]        wind_speed;
    logic [6:0]         weather_code;
    logic               is_day;
  } result_t;

  // Magic byte at header position idx, little endian
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    return REC_MAGIC[{idx, 3'b000} +: 8];
  endfunction

  // One byte through the reflected CRC-32 register
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

### hdl/crcfrd_if.sv
// Interfaces: byte request channel and decoded result channel.
interface crcfrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] blob_byte;
  logic       blob_last;

  modport source (output valid, output blob_byte, output blob_last, input ready);
  modport sink (input valid, input blob_byte, input blob_last, output ready);
endinterface

interface crcfrd_out_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic [63:0]        saved_time;
  logic signed [15:0] temperature;
  logic signed [15:0] apparent_temperature;
  logic [11:0]        wind_speed;
  logic [6:0]         weather_code;
  logic               is_day;

  modport source (output valid, output status, output saved_time, output temperature,
                  output apparent_temperature, output wind_speed, output weather_code,
                  output is_day, input ready);
  modport sink (input valid, input status, input saved_time, input temperature,
                input apparent_temperature, input wind_speed, input weather_code,
                input is_day, output ready);
endinterface

### hdl/crcfrd_in_reg.sv
// Input register: captures one byte request and holds it until the decoder takes it.
module crcfrd_in_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  crcfrd_in_if.sink            in_chan,
  input  logic                 take,
  output logic                 item_valid,
  output crcfrd_pkg::in_item_t item
);

  logic                 valid_r;
  crcfrd_pkg::in_item_t item_r;
  logic                 accept;

  // Accept a new request whenever the register is empty or being drained
  assign in_chan.ready = !valid_r || take;
  assign accept        = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  // Load payload on accept only
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= '{blob_byte: in_chan.blob_byte, blob_last: in_chan.blob_last};
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

### hdl/crcfrd_accum.sv
// Record state: header check, stored check, payload capture, CRC-32 and the final verdict.
module crcfrd_accum (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  crcfrd_pkg::in_item_t item,
  output logic                 res_valid,
  output crcfrd_pkg::result_t  res
);

  logic [4:0]  cnt_r,    cnt_nxt;
  logic [31:0] crc_r,    crc_nxt;
  logic        hdr_r,    hdr_nxt;
  logic [31:0] stored_r, stored_nxt;
  logic [63:0] time_r,   time_nxt;
  logic [63:0] rest_r,   rest_nxt;
  logic [4:0]  time_off;
  logic [4:0]  rest_off;
  logic [7:0]  b;
  logic [15:0] wind;
  logic [7:0]  code;
  logic [7:0]  day;
  logic        ok;

  assign b        = item.blob_byte;
  assign time_off = cnt_r - crcfrd_pkg::POS_TIME_LO;
  assign rest_off = cnt_r - crcfrd_pkg::POS_REST_LO;

  // Fold the current byte into the record state
  always_comb begin
    crc_nxt    = crc_r;
    hdr_nxt    = hdr_r;
    stored_nxt = stored_r;
    time_nxt   = time_r;
    rest_nxt   = rest_r;
    case (cnt_r) inside
      [5'd0:crcfrd_pkg::POS_MAGIC_END]: begin
        if (b != crcfrd_pkg::magic_byte(cnt_r[1:0])) hdr_nxt = 1'b0;
      end
      crcfrd_pkg::POS_VER_LO: begin
        if (b != crcfrd_pkg::REC_VERSION) hdr_nxt = 1'b0;
      end
      crcfrd_pkg::POS_SIZE_LO: begin
        if (b != crcfrd_pkg::REC_SIZE) hdr_nxt = 1'b0;
      end
      crcfrd_pkg::POS_VER_HI, crcfrd_pkg::POS_SIZE_HI: begin
        if (b != crcfrd_pkg::BYTE_ZERO) hdr_nxt = 1'b0;
      end
      [crcfrd_pkg::POS_CHK_LO:crcfrd_pkg::POS_CHK_HI]: begin
        stored_nxt[{cnt_r[1:0], 3'b000} +: 8] = b;
      end
      [crcfrd_pkg::POS_TIME_LO:crcfrd_pkg::POS_TIME_HI]: begin
        time_nxt[{time_off[2:0], 3'b000} +: 8] = b;
        crc_nxt = crcfrd_pkg::crc_byte(crc_r, b);
      end
      [crcfrd_pkg::POS_REST_LO:crcfrd_pkg::POS_REST_HI]: begin
        rest_nxt[{rest_off[2:0], 3'b000} +: 8] = b;
        crc_nxt = crcfrd_pkg::crc_byte(crc_r, b);
      end
      default: begin
        // past the record: ignore the byte
      end
    endcase
    cnt_nxt = (cnt_r < crcfrd_pkg::CNT_SAT) ? cnt_r + 5'd1 : cnt_r;
  end

  // Judge the record on its last byte
  assign wind = rest_nxt[47:32];
  assign code = rest_nxt[55:48];
  assign day  = rest_nxt[63:56];
  assign ok   = (cnt_nxt == crcfrd_pkg::REC_LEN) && hdr_nxt && (~crc_nxt == stored_nxt) &&
                (time_nxt != 64'd0) && (code <= crcfrd_pkg::CODE_MAX) &&
                (wind <= crcfrd_pkg::WIND_MAX) && (day <= crcfrd_pkg::DAY_MAX);

  assign res_valid = fire && item.blob_last;

  always_comb begin
    res = '0;
    if (ok) begin
      res.status               = crcfrd_pkg::STATUS_OK;
      res.saved_time           = time_nxt;
      res.temperature          = $signed(rest_nxt[15:0]);
      res.apparent_temperature = $signed(rest_nxt[31:16]);
      res.wind_speed           = wind[11:0];
      res.weather_code         = code[6:0];
      res.is_day               = day[0];
    end else begin
      res.status = crcfrd_pkg::STATUS_BAD;
    end
  end

  // Advance state per byte; return to reset after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 5'd0;
      crc_r    <= crcfrd_pkg::CRC_INIT;
      hdr_r    <= 1'b1;
      stored_r <= 32'd0;
      time_r   <= 64'd0;
      rest_r   <= 64'd0;
    end else if (fire) begin
      if (item.blob_last) begin
        cnt_r    <= 5'd0;
        crc_r    <= crcfrd_pkg::CRC_INIT;
        hdr_r    <= 1'b1;
        stored_r <= 32'd0;
        time_r   <= 64'd0;
        rest_r   <= 64'd0;
      end else begin
        cnt_r    <= cnt_nxt;
        crc_r    <= crc_nxt;
        hdr_r    <= hdr_nxt;
        stored_r <= stored_nxt;
        time_r   <= time_nxt;
        rest_r   <= rest_nxt;
      end
    end
  end

`ifndef SYNTHESIS
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.blob_last |=> cnt_r == 5'd0)
    else $error("byte count not cleared after last byte");

  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= crcfrd_pkg::CNT_SAT)
    else $error("byte count beyond saturation");

  a_fresh_header: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 5'd0 |-> hdr_r && stored_r == 32'd0)
    else $error("record start without clean header state");

  a_crc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= crcfrd_pkg::POS_TIME_LO |-> crc_r == crcfrd_pkg::CRC_INIT)
    else $error("CRC moved before the payload");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.status == crcfrd_pkg::STATUS_BAD |->
      res.saved_time == 64'd0 && res.wind_speed == 12'd0 && res.is_day == 1'b0)
    else $error("malformed result carries data");
`endif

endmodule

### hdl/crcfrd_out_reg.sv
// Result register: holds one decoded record until the sink takes it.
module crcfrd_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  crcfrd_pkg::result_t res,
  output logic                can_load,
  crcfrd_out_if.source        out_chan
);

  logic                valid_r;
  crcfrd_pkg::result_t res_r;

  // Free when empty or when the held result leaves this cycle
  assign can_load = !valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_chan.valid                = valid_r;
  assign out_chan.status               = res_r.status;
  assign out_chan.saved_time           = res_r.saved_time;
  assign out_chan.temperature          = res_r.temperature;
  assign out_chan.apparent_temperature = res_r.apparent_temperature;
  assign out_chan.wind_speed           = res_r.wind_speed;
  assign out_chan.weather_code         = res_r.weather_code;
  assign out_chan.is_day               = res_r.is_day;

endmodule

### hdl/crc_framed_record_decoder.sv
// Top level: CRC-32 checked 28-byte record decoder with registered input and result.
//
// The decoder takes one record byte per cycle on in_chan, with blob_last on the final
// byte, and gives one result on out_chan per record: status ok with the decoded time,
// temperatures, wind speed, weather code and day flag, or status malformed with all
// data fields zero. A record is ok only if it is exactly 28 bytes, its header carries
// the magic, version 1 and payload size 16, the reflected CRC-32 of the 16 payload
// bytes equals the stored check, and the payload values are in range. A byte is
// accepted every cycle unless a last byte waits for the result register; the rate is
// set by the byte-wide CRC-32 update, done combinationally between the input register
// and the record state. The result of a record is loaded into the result register when
// its last byte leaves the input register, or later while the previous result is still
// held. Bytes of the next record keep flowing while that result waits to be taken; only
// the next last byte waits until the result register is free.
module crc_framed_record_decoder (
  input  logic         clk,
  input  logic         rst_n,
  crcfrd_in_if.sink    in_chan,
  crcfrd_out_if.source out_chan
);

  logic                 item_valid;
  crcfrd_pkg::in_item_t item;
  logic                 take;
  logic                 can_load;
  logic                 res_valid;
  crcfrd_pkg::result_t  res;

  // Drain the input register unless a last byte must wait for the result register
  assign take = item_valid && (!item.blob_last || can_load);

  crcfrd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  crcfrd_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (take),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  crcfrd_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (res_valid),
    .res      (res),
    .can_load (can_load),
    .out_chan (out_chan)
  );

endmodule

### bench/decoded_record_checker.sv
// Checker: predicts the decoded record result from accepted bytes and compares each result.
`timescale 1ns / 100ps
module decoded_record_checker (
  input  logic  clk,
  input  logic  rst_n,
  crcfrd_in_if  in_mon,
  crcfrd_out_if out_mon,
  output int    fail_count,
  output int    outstanding
);

  // Record state as the decoder should hold it
  logic [4:0]          rec_pos;
  logic [31:0]         crc_run;
  logic                hdr_good;
  logic [31:0]         check_word;
  logic [63:0]         time_word;
  logic [63:0]         rest_word;
  int                  mismatches;
  crcfrd_pkg::result_t expected_records [$];

  // Reflected CRC-32 over one byte
  function automatic logic [31:0] crc32_advance(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    r = c ^ {24'd0, d};
    repeat (8) r = r[0] ? ((r >> 1) ^ crcfrd_pkg::CRC_POLY) : (r >> 1);
    return r;
  endfunction

  task automatic clear_record();
    rec_pos    = '0;
    crc_run    = crcfrd_pkg::CRC_INIT;
    hdr_good   = 1'b1;
    check_word = '0;
    time_word  = '0;
    rest_word  = '0;
  endtask

  // Fold one accepted byte into the record; queue the result on the last byte
  task automatic decode_record_byte(input logic [7:0] b, input logic last);
    logic [15:0]         wind;
    logic [7:0]          code;
    logic [7:0]          day;
    logic                good;
    crcfrd_pkg::result_t r;
    if (rec_pos <= crcfrd_pkg::POS_MAGIC_END) begin
      if (b != crcfrd_pkg::REC_MAGIC[8*rec_pos +: 8]) hdr_good = 1'b0;
    end else if (rec_pos == crcfrd_pkg::POS_VER_LO) begin
      if (b != crcfrd_pkg::REC_VERSION) hdr_good = 1'b0;
    end else if (rec_pos == crcfrd_pkg::POS_SIZE_LO) begin
      if (b != crcfrd_pkg::REC_SIZE) hdr_good = 1'b0;
    end else if (rec_pos == crcfrd_pkg::POS_VER_HI || rec_pos == crcfrd_pkg::POS_SIZE_HI) begin
      if (b != crcfrd_pkg::BYTE_ZERO) hdr_good = 1'b0;
    end else if (rec_pos <= crcfrd_pkg::POS_CHK_HI) begin
      check_word[8*(rec_pos - crcfrd_pkg::POS_CHK_LO) +: 8] = b;
    end else if (rec_pos <= crcfrd_pkg::POS_TIME_HI) begin
      time_word[8*(rec_pos - crcfrd_pkg::POS_TIME_LO) +: 8] = b;
      crc_run = crc32_advance(crc_run, b);
    end else if (rec_pos <= crcfrd_pkg::POS_REST_HI) begin
      rest_word[8*(rec_pos - crcfrd_pkg::POS_REST_LO) +: 8] = b;
      crc_run = crc32_advance(crc_run, b);
    end
    // Saturate the count one past the record length
    if (rec_pos < crcfrd_pkg::CNT_SAT) rec_pos = rec_pos + 5'd1;

    if (last) begin
      wind = rest_word[47:32];
      code = rest_word[55:48];
      day  = rest_word[63:56];
      good = (rec_pos == crcfrd_pkg::REC_LEN) && hdr_good && ((~crc_run) == check_word) &&
             (time_word != 64'd0) && (code <= crcfrd_pkg::CODE_MAX) &&
             (wind <= crcfrd_pkg::WIND_MAX) && (day <= crcfrd_pkg::DAY_MAX);
      r = '0;
      if (good) begin
        r.status               = crcfrd_pkg::STATUS_OK;
        r.saved_time           = time_word;
        r.temperature          = rest_word[15:0];
        r.apparent_temperature = rest_word[31:16];
        r.wind_speed           = wind[11:0];
        r.weather_code         = code[6:0];
        r.is_day               = day[0];
      end else begin
        r.status = crcfrd_pkg::STATUS_BAD;
      end
      expected_records.push_back(r);
      clear_record();
    end
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Check results first, then take in the byte request of the same edge
  always @(posedge clk) begin : scoreboard
    crcfrd_pkg::result_t want;
    if (!rst_n) begin
      clear_record();
      expected_records.delete();
      mismatches = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_records.size() == 0) begin
          $display("%0t: result with no record pending, expected none, actual status %0d",
                   $time, out_mon.status);
          mismatches++;
        end else begin
          want = expected_records.pop_front();
          compare_field("status", want.status, out_mon.status);
          compare_field("saved_time", want.saved_time, out_mon.saved_time);
          compare_field("temperature", want.temperature, out_mon.temperature);
          compare_field("apparent_temperature", want.apparent_temperature,
                        out_mon.apparent_temperature);
          compare_field("wind_speed", want.wind_speed, out_mon.wind_speed);
          compare_field("weather_code", want.weather_code, out_mon.weather_code);
          compare_field("is_day", want.is_day, out_mon.is_day);
        end
      end
      if (in_mon.valid && in_mon.ready) decode_record_byte(in_mon.blob_byte, in_mon.blob_last);
    end
    fail_count  <= mismatches;
    outstanding <= expected_records.size();
  end

endmodule

### bench/testbench.sv
// Testbench top: drives record byte streams into the decoder and reports the verdict.
`timescale 1ns / 100ps
module testbench;

  typedef enum {
    REC_GOOD,
    REC_BAD_HEADER,
    REC_BAD_CRC,
    REC_BAD_FIELD,
    REC_SHORT,
    REC_LONG,
    REC_NOISE
  } rec_kind_t;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   outstanding;
  bit   tx_calm;
  bit   rx_calm;
  int   rx_wait;
  logic [7:0] rec_q [$];

  crcfrd_in_if  in_chan ();
  crcfrd_out_if out_chan ();

  crc_framed_record_decoder u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  decoded_record_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #4 clk = ~clk;

  // Stall the result side for a random count after each accepted result
  always @(posedge clk) begin : rx_stall
    int draw;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      rx_wait        <= 0;
    end else if (out_chan.valid && out_chan.ready) begin
      draw = rx_calm ? 0 : $urandom_range(0, 9);
      rx_wait        <= draw;
      out_chan.ready <= (draw == 0);
    end else if (rx_wait > 0) begin
      rx_wait        <= rx_wait - 1;
      out_chan.ready <= (rx_wait == 1);
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  // Payload CRC, one bit at a time, LSB first
  function automatic logic [31:0] payload_crc(input logic [127:0] pay);
    logic [31:0] c;
    logic        fb;
    c = crcfrd_pkg::CRC_INIT;
    for (int k = 0; k < 128; k++) begin
      fb = c[0] ^ pay[k];
      c  = (c >> 1) ^ (fb ? crcfrd_pkg::CRC_POLY : 32'd0);
    end
    return ~c;
  endfunction

  // Build a well-formed 28-byte record in rec_q
  task automatic make_record(input logic [63:0] t, input logic [15:0] tmp,
                             input logic [15:0] atmp, input logic [15:0] wind,
                             input logic [7:0] code, input logic [7:0] day);
    logic [127:0] pay;
    logic [31:0]  chk;
    pay = {day, code, wind, atmp, tmp, t};
    chk = payload_crc(pay);
    rec_q.delete();
    for (int k = 0; k < 4; k++) rec_q.push_back(crcfrd_pkg::REC_MAGIC[8*k +: 8]);
    rec_q.push_back(crcfrd_pkg::REC_VERSION);
    rec_q.push_back(crcfrd_pkg::BYTE_ZERO);
    rec_q.push_back(crcfrd_pkg::REC_SIZE);
    rec_q.push_back(crcfrd_pkg::BYTE_ZERO);
    for (int k = 0; k < 4; k++) rec_q.push_back(chk[8*k +: 8]);
    for (int k = 0; k < 16; k++) rec_q.push_back(pay[8*k +: 8]);
  endtask

  // Hold one byte request until accepted, after a random gap
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.blob_byte <= b;
    in_chan.blob_last <= last;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  task automatic send_record();
    for (int k = 0; k < rec_q.size(); k++) send_byte(rec_q[k], k == rec_q.size() - 1);
  endtask

  initial begin
    rec_kind_t   kind;
    int          pick;
    int          idx;
    int          byte_total;
    logic [63:0] t;
    logic [15:0] tmp;
    logic [15:0] atmp;
    logic [15:0] wind;
    logic [7:0]  code;
    logic [7:0]  day;

    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.blob_byte <= 8'd0;
    in_chan.blob_last <= 1'b0;
    tx_calm           = 1'b0;
    rx_calm           = 1'b0;
    byte_total        = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: good records at the field extremes
    make_record(64'hFFFF_FFFF_FFFF_FFFF, 16'h8000, 16'h7FFF, 16'd3000, 8'd99, 8'd1);
    send_record();
    byte_total += rec_q.size();
    make_record(64'd1, 16'h7FFF, 16'h8000, 16'd0, 8'd0, 8'd0);
    send_record();
    byte_total += rec_q.size();
    // Directed: one-byte record, then a long one past the saturation point
    send_byte(crcfrd_pkg::REC_MAGIC[7:0], 1'b1);
    byte_total += 1;
    make_record(64'h0123_4567_89AB_CDEF, 16'h00FF, 16'hFF00, 16'd1500, 8'd50, 8'd1);
    repeat (3) rec_q.push_back(8'hA5);
    send_record();
    byte_total += rec_q.size();

    // Random records, half of them well formed
    while (byte_total < 950) begin
      tx_calm = ($urandom_range(0, 5) == 0);
      rx_calm = ($urandom_range(0, 5) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 50)      kind = REC_GOOD;
      else if (pick < 58) kind = REC_BAD_HEADER;
      else if (pick < 66) kind = REC_BAD_CRC;
      else if (pick < 80) kind = REC_BAD_FIELD;
      else if (pick < 88) kind = REC_SHORT;
      else if (pick < 94) kind = REC_LONG;
      else                kind = REC_NOISE;

      t    = {$urandom, $urandom};
      if (t == 64'd0) t = 64'd1;
      tmp  = 16'($urandom);
      atmp = 16'($urandom);
      wind = 16'($urandom_range(0, crcfrd_pkg::WIND_MAX));
      code = 8'($urandom_range(0, crcfrd_pkg::CODE_MAX));
      day  = 8'($urandom_range(0, crcfrd_pkg::DAY_MAX));

      // Push one payload value past its limit, often right at the boundary
      if (kind == REC_BAD_FIELD) begin
        case ($urandom_range(0, 3))
          0: t = 64'd0;
          1: code = $urandom_range(0, 1) ? crcfrd_pkg::CODE_MAX + 8'd1 :
                                           8'($urandom_range(100, 255));
          2: wind = $urandom_range(0, 1) ? crcfrd_pkg::WIND_MAX + 16'd1 :
                                           16'($urandom_range(3001, 65535));
          default: day = $urandom_range(0, 1) ? crcfrd_pkg::DAY_MAX + 8'd1 :
                                                8'($urandom_range(2, 255));
        endcase
      end
      make_record(t, tmp, atmp, wind, code, day);

      case (kind)
        REC_BAD_HEADER: begin
          idx = $urandom_range(0, 7);
          rec_q[idx] = rec_q[idx] ^ 8'($urandom_range(1, 255));
        end
        REC_BAD_CRC: begin
          idx = $urandom_range(8, 27);
          rec_q[idx] = rec_q[idx] ^ (8'd1 << $urandom_range(0, 7));
        end
        REC_SHORT: begin
          idx = $urandom_range(1, 27);
          while (rec_q.size() > idx) void'(rec_q.pop_back());
        end
        REC_LONG: begin
          repeat ($urandom_range(1, 6)) rec_q.push_back(8'($urandom));
        end
        REC_NOISE: begin
          rec_q.delete();
          repeat ($urandom_range(1, 40)) rec_q.push_back(8'($urandom));
        end
        default: ;
      endcase

      send_record();
      byte_total += rec_q.size();
    end

    // Drain: drop valid, wait for the last results and let the pipeline settle
    in_chan.valid <= 1'b0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("** crc_framed_record_decoder: PASSED **");
    end else begin
      $display("** crc_framed_record_decoder: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("** crc_framed_record_decoder: FAILED **");
    $finish;
  end

endmodule
